// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds   = 80;

    localparam logic [WordW-1:0] Init0 = 32'h67452301;
    localparam logic [WordW-1:0] Init1 = 32'hEFCDAB89;
    localparam logic [WordW-1:0] Init2 = 32'h98BADCFE;
    localparam logic [WordW-1:0] Init3 = 32'h10325476;
    localparam logic [WordW-1:0] Init4 = 32'hC3D2E1F0;

    localparam logic [7:0] PadByte = 8'h80;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic       byte_we;   // write one byte lane
        logic [5:0] byte_pos;  // byte position inside the block
        logic [7:0] byte_val;
        logic       pad_clr;   // clear words past the padding byte
        logic       low_clr;   // clear words 0..13
        logic       len_we;    // write bit length into words 14 and 15
        logic       shift;     // advance the schedule by one round
        logic       expand;    // round 16 or later: compute new word
    } t_sched_ctl;

    function automatic logic [WordW-1:0] round_k(input logic [1:0] phase);
        logic [WordW-1:0] k;
        case (phase)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    function automatic logic [WordW-1:0] init_word(input logic [2:0] idx);
        logic [WordW-1:0] v;
        case (idx)
            3'd0:    v = Init0;
            3'd1:    v = Init1;
            3'd2:    v = Init2;
            3'd3:    v = Init3;
            default: v = Init4;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sha1_sched.sv =====
module sha1_sched (
    input  logic                i_clk,
    input  sha1_pkg::t_sched_ctl i_ctl,
    input  logic [63:0]         i_len,
    output logic [31:0]         o_wt
);
    import sha1_pkg::*;

    logic [WordW-1:0] r_w [BlkWords];
    logic [WordW-1:0] n_w [BlkWords];
    logic [WordW-1:0] wt;
    logic [WordW-1:0] mix;
    logic [3:0]       wr_idx;
    logic [1:0]       lane;

    assign wr_idx = i_ctl.byte_pos[5:2];
    assign lane   = i_ctl.byte_pos[1:0];

    // Slot 0 holds W[t-16], slot 2 W[t-14], slot 8 W[t-8], slot 13 W[t-3]
    assign mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign wt   = i_ctl.expand ? {mix[WordW-2:0], mix[WordW-1]} : r_w[0];
    assign o_wt = wt;

    always_comb begin
        for (int i = 0; i < BlkWords; i++) begin
            if (i_ctl.shift) begin
                n_w[i] = (i == BlkWords - 1) ? wt : r_w[(i + 1) % BlkWords];
            end else begin
                n_w[i] = r_w[i];
                if (i_ctl.low_clr && i < BlkWords - 2) begin
                    n_w[i] = '0;
                end
                if (i_ctl.pad_clr && 4'(i) > wr_idx) begin
                    n_w[i] = '0;
                end
                if (i_ctl.byte_we && 4'(i) == wr_idx) begin
                    // first byte of a word overwrites the whole word
                    if (lane == 2'd0) begin
                        n_w[i] = {i_ctl.byte_val, 24'd0};
                    end else begin
                        n_w[i][{~lane, 3'b000} +: 8] = i_ctl.byte_val;
                    end
                end
                if (i_ctl.len_we && i == BlkWords - 2) begin
                    n_w[i] = i_len[63:32];
                end
                if (i_ctl.len_we && i == BlkWords - 1) begin
                    n_w[i] = i_len[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BlkWords; i++) begin
            r_w[i] <= n_w[i];
        end
    end

endmodule

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 engine fed one message byte per beat. A beat with tuser high carries a byte;
// tlast closes the message and may come on a bare beat so empty messages hash too.
// A plain byte leaves the input ready. The byte that completes a 64-byte block drops
// the input while the block is compressed: one round per cycle through a single
// shared round unit for 80 rounds, then an add into the chaining value. The closing
// beat passes through the pad and length steps, one more block when more than 55
// bytes are pending, the final block, and then five digest beats, most significant
// word first, with the word position on tuser and tlast on the fifth. The engine
// then returns to the initial chaining value and zero length for the next message.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] msg_byte
    input  logic        i_s_tuser,   // [0] has_byte
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_index
    output logic        o_m_tlast    // last_word
);
    import sha1_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    t_state           r_after, n_after;
    logic [6:0]       r_rnd, n_rnd;
    logic [2:0]       r_oidx, n_oidx;
    logic             r_extra, n_extra;
    logic [63:0]      r_cnt, n_cnt;
    logic [WordW-1:0] r_chain [5];
    logic [WordW-1:0] n_chain [5];
    logic [WordW-1:0] r_v [5];
    logic [WordW-1:0] n_v [5];

    t_sched_ctl       ctl;
    logic [WordW-1:0] wt;
    logic [WordW-1:0] f;
    logic [1:0]       phase;
    logic [WordW-1:0] tmp;
    logic             s_acc;
    logic             m_acc;
    logic             start;

    sha1_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_len ({r_cnt[60:0], 3'b000}),
        .o_wt  (wt)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = r_chain[r_oidx];
    assign o_m_tuser  = r_oidx;
    assign o_m_tlast  = (r_oidx == 3'd4);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = o_m_tvalid && i_m_tready;

    // Shared round unit
    always_comb begin
        if (r_rnd < 7'd20) begin
            phase = 2'd0;
        end else if (r_rnd < 7'd40) begin
            phase = 2'd1;
        end else if (r_rnd < 7'd60) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
        case (phase)
            2'd0:    f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            2'd2:    f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            default: f = r_v[1] ^ r_v[2] ^ r_v[3];
        endcase
        tmp = {r_v[0][26:0], r_v[0][31:27]} + f + r_v[4] + wt + round_k(phase);
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_extra = r_extra;
        n_cnt   = r_cnt;
        start   = 1'b0;
        for (int i = 0; i < 5; i++) begin
            n_chain[i] = r_chain[i];
            n_v[i]     = r_v[i];
        end
        ctl          = '0;
        ctl.byte_pos = r_cnt[5:0];
        ctl.byte_val = i_s_tdata;
        ctl.expand   = (r_rnd >= 7'd16);

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser) begin
                        ctl.byte_we = 1'b1;
                        n_cnt       = r_cnt + 64'd1;
                    end
                    if (i_s_tuser && r_cnt[5:0] == 6'd63) begin
                        start   = 1'b1;
                        n_after = i_s_tlast ? S_PAD : S_IDLE;
                    end else if (i_s_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                ctl.byte_we  = 1'b1;
                ctl.byte_val = PadByte;
                ctl.pad_clr  = 1'b1;
                if (r_cnt[5:0] > 6'd55) begin
                    start   = 1'b1;
                    n_after = S_LEN;
                    n_extra = 1'b1;
                end else begin
                    n_state = S_LEN;
                    n_extra = 1'b0;
                end
            end
            S_LEN: begin
                ctl.len_we  = 1'b1;
                ctl.low_clr = r_extra;
                start       = 1'b1;
                n_after     = S_OUT;
            end
            S_ROUND: begin
                ctl.shift = 1'b1;
                n_v[4]    = r_v[3];
                n_v[3]    = r_v[2];
                n_v[2]    = {r_v[1][1:0], r_v[1][31:2]};
                n_v[1]    = r_v[0];
                n_v[0]    = tmp;
                n_rnd     = r_rnd + 7'd1;
                if (r_rnd == 7'(Rounds - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                n_state = r_after;
                n_oidx  = 3'd0;
            end
            S_OUT: begin
                if (m_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd4) begin
                        // rewind for the next message
                        for (int i = 0; i < 5; i++) begin
                            n_chain[i] = init_word(3'(i));
                        end
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (start) begin
            n_state = S_ROUND;
            n_rnd   = '0;
            for (int i = 0; i < 5; i++) begin
                n_v[i] = r_chain[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_extra <= 1'b0;
            r_cnt   <= '0;
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= init_word(3'(i));
            end
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_extra <= n_extra;
            r_cnt   <= n_cnt;
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= n_chain[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 5; i++) begin
            r_v[i] <= n_v[i];
        end
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while digest beats pending");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd < 7'(Rounds)))
        else $error("round counter past last round");

    a_round_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_rnd == 7'(Rounds - 1)) |=> (r_state == S_ADD))
        else $error("compression did not end after the last round");

    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_tlast) |=> (o_s_tready && r_cnt == 64'd0 && r_chain[0] == Init0))
        else $error("engine not rewound after the digest");

    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_oidx < 3'd5))
        else $error("digest word position out of range");
`endif

endmodule

// ===== tb/sv/tb_sha1_hash_engine.sv =====
module tb_sha1_hash_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned DrainCycles = 200;
    localparam int unsigned RandItems = 90;
    localparam int unsigned RandMsgsMin = 2;
    localparam int unsigned MaxReported = 10;

    localparam logic [31:0] IvWord [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] KStage [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam logic [7:0] PadMarker = 8'h80;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE
    } t_rx_mode;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [7:0] msg_byte
    logic        i_s_tuser = 1'b0; // [0] has_byte
    logic        i_s_tlast = 1'b0; // end_of_message
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // [31:0] digest_word
    logic [2:0]  o_m_tuser;        // [2:0] word_index
    logic        o_m_tlast;        // last_word

    sha1_hash_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // hash state mirrored from the engine
    logic [31:0] sha_chain [5];
    logic [31:0] sha_block [16];
    logic [63:0] sha_nbytes;

    t_digest_beat digest_q [$];

    int unsigned n_errors = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;

    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_phase_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < 5; i++) sha_chain[i] = IvWord[i];
        for (int i = 0; i < 16; i++) sha_block[i] = '0;
        sha_nbytes = '0;
    endfunction

    function automatic void absorb_byte(input logic [5:0] pos, input logic [7:0] b);
        logic [31:0] lane;
        lane = {24'h0, b} << ((3 - pos[1:0]) * 8);
        if (pos[1:0] == 2'd0) begin
            sha_block[pos[5:2]] = lane;
        end else begin
            sha_block[pos[5:2]] |= lane;
        end
    endfunction

    function automatic void sha_compress();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int n = 0; n < 80; n++) begin
            if (n >= 16) begin
                w = rol32(sha_block[(n - 3) & 15] ^ sha_block[(n - 8) & 15] ^
                          sha_block[(n - 14) & 15] ^ sha_block[n & 15], 1);
                sha_block[n & 15] = w;
            end else begin
                w = sha_block[n];
            end
            if (n < 20) begin
                f = (b & c) | (~b & d);
                k = KStage[0];
            end else if (n < 40) begin
                f = b ^ c ^ d;
                k = KStage[1];
            end else if (n < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = KStage[2];
            end else begin
                f = b ^ c ^ d;
                k = KStage[3];
            end
            t = rol32(a, 5) + f + e + w + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endfunction

    function automatic void predict_digest(input logic [7:0] b, input logic has,
                                           input logic eom);
        logic [5:0]   r;
        logic [63:0]  bits;
        t_digest_beat d;
        if (has) begin
            absorb_byte(sha_nbytes[5:0], b);
            sha_nbytes += 64'd1;
            if (sha_nbytes[5:0] == 6'd0) sha_compress();
        end
        if (!eom) return;
        r = sha_nbytes[5:0];
        absorb_byte(r, PadMarker);
        for (int i = int'(r[5:2]) + 1; i < 16; i++) sha_block[i] = '0;
        // length field does not fit: flush this block, length goes in an extra one
        if (r > 6'd55) begin
            sha_compress();
            for (int i = 0; i < 14; i++) sha_block[i] = '0;
        end
        bits = sha_nbytes << 3;
        sha_block[14] = bits[63:32];
        sha_block[15] = bits[31:0];
        sha_compress();
        for (int i = 0; i < 5; i++) begin
            d.word = sha_chain[i];
            d.idx  = 3'(i);
            d.last = (i == 4);
            digest_q.push_back(d);
        end
        for (int i = 0; i < 5; i++) sha_chain[i] = IvWord[i];
        sha_nbytes = '0;
    endfunction

    // send one beat in bursts with random gaps, predict on acceptance
    task automatic send_beat(input logic [7:0] b, input logic has, input logic eom);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= has;
        i_s_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_digest(b, has, eom);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned len, input logic close_on_data);
        for (int unsigned i = 0; i < len; i++) begin
            // sprinkle beats the engine must skip
            if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, close_on_data && (i == len - 1));
        end
        if (!close_on_data || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_close_on_byte();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_close_on_bare_marker();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned msgs;
        int unsigned start;
        int unsigned len;
        int unsigned pick;
        msgs  = 0;
        start = items_sent;
        while (items_sent - start < RandItems || msgs < RandMsgsMin) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) len = $urandom_range(0, 8);
            else if (pick < 8) len = $urandom_range(50, 70);   // padding boundaries
            else len = $urandom_range(0, 140);
            send_message(len, 1'($urandom_range(0, 1)));
            msgs++;
        end
    endtask

    // receiver stall pattern: phases of always-ready, coin flip and heavy choke
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       <= t_rx_mode'($urandom_range(0, 2));
                rx_phase_left <= $urandom_range(10, 60);
            end else begin
                rx_phase_left <= rx_phase_left - 1;
            end
            case (rx_mode)
                RX_OPEN:  i_m_tready <= 1'b1;
                RX_COIN:  i_m_tready <= 1'($urandom_range(0, 1));
                default:  i_m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (digest_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MaxReported)
                    $display("unexpected digest beat: word %h idx %0d last %b",
                             o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                want = digest_q.pop_front();
                if (o_m_tdata !== want.word || o_m_tuser !== want.idx ||
                    o_m_tlast !== want.last) begin
                    n_errors++;
                    if (n_errors <= MaxReported)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.word, want.idx, want.last,
                                 o_m_tdata, o_m_tuser, o_m_tlast);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        sha_restart();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_close_on_byte();
        test_close_on_bare_marker();
        test_byte_extremes();
        test_random_messages();

        i_s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (n_errors == 0 && digest_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sha1_hash_engine.f =====
rtl/sha1_pkg.sv
rtl/sha1_sched.sv
rtl/sha1_hash_engine.sv
tb/sv/tb_sha1_hash_engine.sv
